// ----- hdl/rsvg_pkg.sv -----
// ============================================================================
// Ring sector vertex generator: shared types and constants
// Field widths, register and status codes, CORDIC angle table and the
// fixed-point constants used by the pipeline cells.
// ============================================================================
package rsvg_pkg;

    localparam int CNT_W      = 12;
    localparam int RAD_W      = 16;
    localparam int ANG_W      = 16;
    localparam int POS_W      = 17;
    localparam int UV_W       = 16;
    localparam int T_W        = 16;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CW         = 33;
    localparam int PROD_W     = CW + RAD_W + 1;
    localparam int PM_W       = 33;
    localparam int PQ_W       = 17;
    localparam int QV_W       = 37;

    localparam logic signed [QV_W-1:0] HALF_PI_Q30    = 37'sd1686629713;
    localparam logic signed [QV_W-1:0] QUARTER_PI_Q30 = 37'sd843314856;
    localparam logic signed [CW-1:0]   GAIN_Q30       = 33'sd652032874;
    localparam logic [UV_W-1:0]        UV_HALF        = 16'd16384;
    localparam logic [UV_W-1:0]        UV_ONE         = 16'd32768;
    localparam logic signed [POS_W-1:0] POS_MAX       = 17'sd65535;

    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEGMENT_COUNT = 3'd0,
        REG_FIRST_RADIUS  = 3'd1,
        REG_SECOND_RADIUS = 3'd2,
        REG_START_ANGLE   = 3'd3,
        REG_END_ANGLE     = 3'd4,
        REG_UV_MODE       = 3'd5
    } cfg_index_e;

    typedef enum logic [ST_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BEYOND     = 2'd1,
        STATUS_ZERO_OUTER = 2'd2
    } status_e;

    typedef logic signed [POS_W-1:0] pos_t;

    typedef struct packed {
        logic           bad;
        logic [T_W-1:0] t;
        logic [1:0]     quad;
        pos_t           ix;
        pos_t           iy;
        pos_t           ox;
        pos_t           oy;
        logic [3:0]     neg;
    } side_t;

    function automatic logic signed [QV_W-1:0] quad_base(input logic signed [3:0] q);
        return QV_W'(q) * HALF_PI_Q30;
    endfunction

endpackage

// ----- hdl/ring_sector_vertex_generator.sv -----
// ============================================================================
// Ring sector vertex generator
// Turns a spoke index into the inner and outer vertex of a ring sector with
// texture coordinates, through a divider chain, a CORDIC chain and four
// projection divider chains.
//
//   channel   direction   beat contents
//   s_        in          segment_index
//   m_        out         inner/outer x, y, u, v and status
//   cfg_      in          register index and write data
//
// One beat enters per cycle while no result beat waits at the output.
// The chain length is set by the 16-bit and 17-bit quotient divider cells
// and the CORDIC cells. The whole chain advances together and holds when a
// result beat waits at the output. Reset clears the valid flags and loads
// the register defaults.
// ============================================================================
module ring_sector_vertex_generator
    import rsvg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int INDEX_BITS    = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [INDEX_BITS-1:0] s_segment_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [POS_W-1:0] m_inner_x,
    output logic signed [POS_W-1:0] m_inner_y,
    output logic signed [POS_W-1:0] m_outer_x,
    output logic signed [POS_W-1:0] m_outer_y,
    output logic [UV_W-1:0]       m_inner_u,
    output logic [UV_W-1:0]       m_inner_v,
    output logic [UV_W-1:0]       m_outer_u,
    output logic [UV_W-1:0]       m_outer_v,
    output logic [ST_W-1:0]       m_status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CS     = CORDIC_STAGES;
    localparam int IW     = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;
    localparam int TN_W   = INDEX_BITS + 16;
    localparam int MUL    = T_W + 1;
    localparam int ANG    = MUL + 1;
    localparam int QUAD   = ANG + 1;
    localparam int RED    = QUAD + 1;
    localparam int ROT    = RED + 1 + CS;
    localparam int PROD   = ROT + 1;
    localparam int POS    = PROD + 1;
    localparam int PREP   = POS + 1;
    localparam int NS     = PREP + PQ_W + 1;
    localparam int LAST   = NS - 1;

    // Configuration registers.
    logic [CNT_W-1:0]        cnt_reg;
    logic [RAD_W-1:0]        r1_reg, r2_reg;
    logic signed [ANG_W-1:0] sa_reg, ea_reg;
    logic                    uv_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= CNT_W'(32);
            r1_reg      <= RAD_W'(128);
            r2_reg      <= RAD_W'(256);
            sa_reg      <= '0;
            ea_reg      <= ANG_W'(25736);
            uv_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index_e'(cfg_index))
                REG_SEGMENT_COUNT: cnt_reg     <= cfg_data[CNT_W-1:0];
                REG_FIRST_RADIUS:  r1_reg      <= cfg_data;
                REG_SECOND_RADIUS: r2_reg      <= cfg_data;
                REG_START_ANGLE:   sa_reg      <= cfg_data;
                REG_END_ANGLE:     ea_reg      <= cfg_data;
                REG_UV_MODE:       uv_mode_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic [RAD_W-1:0] rin, rout;
    assign rin  = (r1_reg < r2_reg) ? r1_reg : r2_reg;
    assign rout = (r1_reg < r2_reg) ? r2_reg : r1_reg;

    // Chain control.
    logic            adv;
    logic            m_valid_reg;
    logic [NS-1:0]   valid_reg;
    side_t           side_reg  [NS];
    side_t           side_next [NS];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[NS-2:0], s_valid};
        end
    end

    // Input stage.
    logic            in_bad;
    logic [TN_W-1:0] n_reg;

    assign in_bad = (cnt_reg == '0) || (IW'(s_segment_index) > IW'(cnt_reg));

    always_ff @(posedge aclk) begin
        if (adv) begin
            n_reg <= TN_W'({s_segment_index, 15'b0}) + TN_W'(cnt_reg >> 1);
        end
    end

    // Spoke parameter divider chain.
    logic [TN_W-1:0] trem [T_W+1];
    logic [T_W-1:0]  tquo [T_W+1];

    assign trem[0] = n_reg;
    assign tquo[0] = '0;

    for (genvar k = 0; k < T_W; k++) begin : g_tdiv
        rsvg_div_cell #(
            .REM_W(TN_W), .DEN_W(CNT_W), .QUO_W(T_W), .BIT(T_W - 1 - k)
        ) u_cell (
            .aclk(aclk), .en(adv),
            .rem_in(trem[k]), .quo_in(tquo[k]), .den(cnt_reg),
            .rem_out(trem[k+1]), .quo_out(tquo[k+1])
        );
    end

    // Angle interpolation and quadrant reduction.
    logic signed [ANG_W:0]   diff;
    logic signed [2*ANG_W+1:0] prod_reg;
    logic signed [ANG_W:0]   ang_reg, ang2_reg;
    logic signed [QV_W-1:0]  qval, zfull;
    logic [3:0]              qcnt;
    logic signed [3:0]       q_reg;
    logic signed [CW-1:0]    cx [CS+1];
    logic signed [CW-1:0]    cy [CS+1];
    logic signed [CW-1:0]    cz [CS+1];
    logic signed [CW-1:0]    x0_reg, y0_reg, z0_reg;

    assign diff = (ANG_W+1)'(ea_reg) - (ANG_W+1)'(sa_reg);

    always_comb begin
        qval = (QV_W'(ang_reg) <<< 18) + QUARTER_PI_Q30;
        qcnt = '0;
        for (int j = -4; j <= 5; j++) begin
            if (qval >= quad_base(4'(j))) begin
                qcnt = qcnt + 4'd1;
            end
        end
        zfull = (QV_W'(ang2_reg) <<< 18) - quad_base(q_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= diff * $signed({1'b0, tquo[T_W]});
            ang_reg  <= (ANG_W+1)'((2*ANG_W+2)'(sa_reg)
                        + ((prod_reg + 34'sd16384) >>> 15));
            q_reg    <= $signed(qcnt - 4'd5);
            ang2_reg <= ang_reg;
            x0_reg   <= GAIN_Q30;
            y0_reg   <= '0;
            z0_reg   <= CW'(zfull);
        end
    end

    // CORDIC chain.
    assign cx[0] = x0_reg;
    assign cy[0] = y0_reg;
    assign cz[0] = z0_reg;

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        rsvg_cordic_cell #(.STAGE(i)) u_cell (
            .aclk(aclk), .en(adv),
            .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
            .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
        );
    end

    // Quadrant rotation, radius scaling and position rounding.
    logic signed [CW-1:0]     c_reg, s_reg;
    logic signed [CW-1:0]     c_next, s_next;
    logic signed [PROD_W-1:0] pr_reg [4];
    pos_t                     pos_val [4];

    always_comb begin
        case (side_reg[ROT-1].quad)
            2'd0: begin
                c_next = cx[CS];
                s_next = cy[CS];
            end
            2'd1: begin
                c_next = -cy[CS];
                s_next = cx[CS];
            end
            2'd2: begin
                c_next = -cx[CS];
                s_next = -cy[CS];
            end
            default: begin
                c_next = cy[CS];
                s_next = -cx[CS];
            end
        endcase
    end

    function automatic pos_t round_pos(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        r = (p + (PROD_W'(1) <<< 29)) >>> 30;
        if (r > PROD_W'(POS_MAX)) begin
            return POS_MAX;
        end else if (r < -PROD_W'(POS_MAX)) begin
            return -POS_MAX;
        end
        return POS_W'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_reg     <= c_next;
            s_reg     <= s_next;
            pr_reg[0] <= c_reg * $signed({1'b0, rin});
            pr_reg[1] <= s_reg * $signed({1'b0, rin});
            pr_reg[2] <= c_reg * $signed({1'b0, rout});
            pr_reg[3] <= s_reg * $signed({1'b0, rout});
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_pos
        assign pos_val[l] = round_pos(pr_reg[l]);
    end

    // Flat projection: sign handling, then floor division by twice outer.
    logic [PQ_W-1:0]        den2;
    logic signed [34:0]     pn [4];
    logic signed [34:0]     pmag [4];
    logic [PM_W-1:0]        pm_reg [4];
    logic [PM_W-1:0]        prem [4][PQ_W+1];
    logic [PQ_W-1:0]        pquo [4][PQ_W+1];
    pos_t                   ppos [4];

    assign den2 = {rout, 1'b0};
    assign ppos[0] = side_reg[POS].ix;
    assign ppos[1] = side_reg[POS].iy;
    assign ppos[2] = side_reg[POS].ox;
    assign ppos[3] = side_reg[POS].oy;

    for (genvar l = 0; l < 4; l++) begin : g_proj
        assign pn[l]   = (35'(ppos[l]) <<< 15) + 35'(rout);
        assign pmag[l] = pn[l][34] ? (-pn[l] + 35'(den2) - 35'sd1) : pn[l];

        always_ff @(posedge aclk) begin
            if (adv) begin
                pm_reg[l] <= PM_W'(pmag[l]);
            end
        end

        assign prem[l][0] = pm_reg[l];
        assign pquo[l][0] = '0;

        for (genvar k = 0; k < PQ_W; k++) begin : g_cell
            rsvg_div_cell #(
                .REM_W(PM_W), .DEN_W(PQ_W), .QUO_W(PQ_W), .BIT(PQ_W - 1 - k)
            ) u_cell (
                .aclk(aclk), .en(adv),
                .rem_in(prem[l][k]), .quo_in(pquo[l][k]), .den(den2),
                .rem_out(prem[l][k+1]), .quo_out(pquo[l][k+1])
            );
        end
    end

    // Sideband that travels with each beat.
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                side_next[k]     = '0;
                side_next[k].bad = in_bad;
            end else begin
                side_next[k] = side_reg[k-1];
                if (k == MUL) begin
                    side_next[k].t = tquo[T_W];
                end
                if (k == RED) begin
                    side_next[k].quad = q_reg[1:0];
                end
                if (k == POS) begin
                    side_next[k].ix = pos_val[0];
                    side_next[k].iy = pos_val[1];
                    side_next[k].ox = pos_val[2];
                    side_next[k].oy = pos_val[3];
                end
                if (k == PREP) begin
                    side_next[k].neg = {pn[3][34], pn[2][34], pn[1][34], pn[0][34]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NS; k++) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // Output stage.
    function automatic logic [UV_W-1:0] clamp_uv(input logic signed [PQ_W+1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > (PQ_W+2)'(UV_ONE)) begin
            return UV_ONE;
        end
        return UV_W'(v);
    endfunction

    side_t                  fin;
    logic signed [PQ_W:0]   pv [4];
    logic [UV_W-1:0]        uv_flat [4];

    assign fin = side_reg[LAST];

    for (genvar l = 0; l < 4; l++) begin : g_uv
        assign pv[l] = fin.neg[l] ? -(PQ_W+1)'(pquo[l][PQ_W]) : (PQ_W+1)'(pquo[l][PQ_W]);
        if (l % 2 == 0) begin : g_u
            assign uv_flat[l] = clamp_uv((PQ_W+2)'(UV_HALF) + (PQ_W+2)'(pv[l]));
        end else begin : g_v
            assign uv_flat[l] = clamp_uv((PQ_W+2)'(UV_HALF) - (PQ_W+2)'(pv[l]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (fin.bad) begin
                m_inner_x <= '0;
                m_inner_y <= '0;
                m_outer_x <= '0;
                m_outer_y <= '0;
                m_inner_u <= '0;
                m_inner_v <= '0;
                m_outer_u <= '0;
                m_outer_v <= '0;
                m_status  <= STATUS_BEYOND;
            end else if (!uv_mode_reg) begin
                m_inner_x <= fin.ix;
                m_inner_y <= fin.iy;
                m_outer_x <= fin.ox;
                m_outer_y <= fin.oy;
                m_inner_u <= fin.t;
                m_inner_v <= '0;
                m_outer_u <= fin.t;
                m_outer_v <= UV_ONE;
                m_status  <= STATUS_OK;
            end else if (rout == '0) begin
                m_inner_x <= '0;
                m_inner_y <= '0;
                m_outer_x <= '0;
                m_outer_y <= '0;
                m_inner_u <= UV_HALF;
                m_inner_v <= UV_HALF;
                m_outer_u <= UV_HALF;
                m_outer_v <= UV_HALF;
                m_status  <= STATUS_ZERO_OUTER;
            end else begin
                m_inner_x <= fin.ix;
                m_inner_y <= fin.iy;
                m_outer_x <= fin.ox;
                m_outer_y <= fin.oy;
                m_inner_u <= uv_flat[0];
                m_inner_v <= uv_flat[1];
                m_outer_u <= uv_flat[2];
                m_outer_v <= uv_flat[3];
                m_status  <= STATUS_OK;
            end
        end
    end

    // Assertions.
    a_beyond_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_BEYOND |->
            m_inner_x == '0 && m_outer_y == '0 && m_inner_u == '0 && m_outer_v == '0)
        else $error("beyond-count beat carries nonzero fields");

    a_zero_outer_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_ZERO_OUTER |->
            uv_mode_reg && m_inner_u == UV_HALF && m_outer_v == UV_HALF)
        else $error("zero outer radius status outside flat mode");

    a_chain_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LAST] && adv |=> m_valid)
        else $error("beat lost between chain and output register");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

// ----- hdl/rsvg_div_cell.sv -----
// ============================================================================
// Restoring divider cell
// Resolves one quotient bit per cell and passes the partial remainder on.
// ============================================================================
module rsvg_div_cell #(
    parameter int REM_W = 33,
    parameter int DEN_W = 17,
    parameter int QUO_W = 17,
    parameter int BIT   = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [REM_W-1:0] rem_in,
    input  logic [QUO_W-1:0] quo_in,
    input  logic [DEN_W-1:0] den,
    output logic [REM_W-1:0] rem_out,
    output logic [QUO_W-1:0] quo_out
);

    localparam int SH_W  = DEN_W + BIT;
    localparam int CMP_W = (SH_W > REM_W) ? SH_W : REM_W;

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] den_sh;
    logic             take;

    always_comb begin
        rem_ext  = CMP_W'(rem_in);
        den_sh   = CMP_W'(den) << BIT;
        take     = rem_ext >= den_sh;
        rem_next = take ? REM_W'(rem_ext - den_sh) : rem_in;
        quo_next = quo_in | (QUO_W'(take) << BIT);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

// ----- hdl/rsvg_cordic_cell.sv -----
// ============================================================================
// CORDIC rotation cell
// One micro-rotation toward zero residual angle, registered.
// ============================================================================
module rsvg_cordic_cell
    import rsvg_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out
);

    localparam logic signed [CW-1:0] ATAN = CW'(ATAN_Q30[STAGE]);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] dx, dy;

    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (z_in >= 0) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
